// ----- rtl/sfol_pkg.sv -----
// ----------------------------------------------------------------------------
// sfol_pkg
// Shared types and constants of the stack frame operand and locals unit.
// ----------------------------------------------------------------------------
package sfol_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 8;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 9;
  localparam int APB_W     = 32;
  localparam int APB_AW    = 3;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_FRAME_SLOTS = 256;
  localparam int DEF_WORD_WIDTH  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ARG_COUNT   = 1'b0;
  localparam logic REG_LOCAL_COUNT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH,
    K_POP,
    K_PEEK,
    K_LOAD_LOCAL,
    K_LOAD_ARG,
    K_STORE_LOCAL,
    K_STORE_ARG,
    K_NOP
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_RANGE,
    STAT_FULL
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    status_t stat;
    logic    from_stack;
    logic    from_slot;
    logic    not_empty;
  } pend_t;

endpackage

// ----- rtl/sfol_ram.sv -----
// ----------------------------------------------------------------------------
// sfol_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfol_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/stack_frame_operand_and_locals_unit_top.sv -----
// ----------------------------------------------------------------------------
// stack_frame_operand_and_locals_unit_top
// Frame store of a stack VM: evaluation stack plus argument/local slot store.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_stall, kind, slot_index,    | item into block
//           | data_in                                  |
//   out     | out_valid, out_stall, data_out, status,  | result out of block
//           | stack_not_empty                          |
//   cfg     | APB: psel, penable, pwrite, paddr, ...   | arg/local counts
//
// For each item, the accept edge issues the memory read or write, and the
// result is registered from the RAM read data once the output is free.
// After reset the slot store is cleared, with in_stall high.
// While out_stall holds a result, one more item is taken and the next waits.
// Reset is synchronous, active high; config is taken at any time.
// ----------------------------------------------------------------------------
module stack_frame_operand_and_locals_unit_top #(
  parameter int STACK_DEPTH = sfol_pkg::DEF_STACK_DEPTH,
  parameter int FRAME_SLOTS = sfol_pkg::DEF_FRAME_SLOTS,
  parameter int WORD_WIDTH  = sfol_pkg::DEF_WORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sfol_pkg::KIND_W-1:0] kind,
  input  logic [sfol_pkg::IDX_W-1:0]  slot_index,
  input  logic [sfol_pkg::DATA_W-1:0] data_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sfol_pkg::DATA_W-1:0] data_out,
  output logic [sfol_pkg::STAT_W-1:0] status,
  output logic                        stack_not_empty,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfol_pkg::APB_AW-1:0] paddr,
  input  logic [sfol_pkg::APB_W-1:0]  pwdata,
  output logic [sfol_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);

  import sfol_pkg::*;

  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int CW      = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_AW = $clog2(FRAME_SLOTS);
  localparam int TW      = (SLOT_AW + 1 > CFG_W + 1) ? SLOT_AW + 1 : CFG_W + 1;
  localparam int SW      = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;

  localparam logic [CW-1:0]      STK_FULL = CW'(STACK_DEPTH);
  localparam logic [TW-1:0]      SLOTS_T  = TW'(FRAME_SLOTS);
  localparam logic [SLOT_AW-1:0] CLR_LAST = SLOT_AW'(FRAME_SLOTS - 1);

  state_t             state, state_next;
  logic [CW-1:0]      stack_count, stack_count_next;
  logic [CFG_W-1:0]   arg_count, local_count;
  logic [SLOT_AW-1:0] clr_addr;
  pend_t              pend, pend_next;

  kind_t              kind_e;
  logic               accept, out_free, load_out, slot_ok, is_local;
  logic [TW-1:0]      total, slot;
  logic [CW-1:0]      stk_dec;

  logic               stk_we, stk_re, slot_we, slot_re;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SW-1:0]      slot_wdata, stk_rdata, slot_rdata;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_count   <= '0;
      local_count <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ARG_COUNT:   arg_count   <= pwdata[CFG_W-1:0];
        REG_LOCAL_COUNT: local_count <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ARG_COUNT:   prdata = APB_W'(arg_count);
      REG_LOCAL_COUNT: prdata = APB_W'(local_count);
      default:         prdata = '0;
    endcase
  end

  // bounds
  assign kind_e   = kind_t'(kind);
  assign is_local = (kind_e == K_LOAD_LOCAL) || (kind_e == K_STORE_LOCAL);
  assign total    = TW'(arg_count) + TW'(local_count);
  assign slot     = is_local ? TW'(arg_count) + TW'(slot_index) : TW'(slot_index);
  assign slot_ok  = (slot < total) && (slot < SLOTS_T);
  assign stk_dec  = stack_count - CW'(1);

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == CLR_LAST) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall         = (state != S_IDLE);
    load_out         = (state == S_EXEC) && out_free;
    stk_we           = 1'b0;
    stk_re           = 1'b0;
    slot_we          = 1'b0;
    slot_re          = 1'b0;
    stk_waddr        = stack_count[STK_AW-1:0];
    stk_raddr        = stk_dec[STK_AW-1:0];
    slot_waddr       = slot[SLOT_AW-1:0];
    slot_wdata       = data_in[SW-1:0];
    stack_count_next = stack_count;
    pend_next        = pend;

    if (state == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_addr;
      slot_wdata = '0;
    end

    if (accept) begin
      pend_next = '{stat: STAT_OK, from_stack: 1'b0, from_slot: 1'b0, not_empty: 1'b0};
      case (kind_e)
        K_PUSH: begin
          if (stack_count == STK_FULL) begin
            pend_next.stat = STAT_FULL;
          end else begin
            stk_we           = 1'b1;
            stack_count_next = stack_count + CW'(1);
          end
        end
        K_POP, K_PEEK: begin
          if (stack_count == '0) begin
            pend_next.stat = STAT_EMPTY;
          end else begin
            stk_re               = 1'b1;
            pend_next.from_stack = 1'b1;
            if (kind_e == K_POP) stack_count_next = stk_dec;
          end
        end
        K_LOAD_LOCAL, K_LOAD_ARG: begin
          if (!slot_ok) begin
            pend_next.stat = STAT_RANGE;
          end else begin
            slot_re             = 1'b1;
            pend_next.from_slot = 1'b1;
          end
        end
        K_STORE_LOCAL, K_STORE_ARG: begin
          if (!slot_ok) pend_next.stat = STAT_RANGE;
          else          slot_we        = 1'b1;
        end
        default: ;
      endcase
      pend_next.not_empty = (stack_count_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      stack_count <= '0;
      clr_addr    <= '0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + SLOT_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend <= pend_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      data_out        <= pend.from_stack ? DATA_W'(stk_rdata) :
                         pend.from_slot  ? DATA_W'(slot_rdata) : '0;
      status          <= pend.stat;
      stack_not_empty <= pend.not_empty;
    end
  end

  sfol_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (SW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (data_in[SW-1:0]),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  sfol_ram #(
    .DEPTH (FRAME_SLOTS),
    .WIDTH (SW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot[SLOT_AW-1:0]),
    .rdata (slot_rdata)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= STK_FULL)
    else $error("stack count above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    accept && (kind_e == K_PUSH) && (stack_count != STK_FULL)
      |=> stack_count == $past(stack_count) + CW'(1))
    else $error("push did not advance stack count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status_t'(status) == STAT_EMPTY) |-> !stack_not_empty)
    else $error("empty status with stack flag set");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status_t'(status) == STAT_FULL) |-> stack_not_empty)
    else $error("full status with stack flag clear");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the stack frame operand and locals unit. A directed table covers
// the empty stack, zero slots, the slot bounds and the unused kind. Random
// phases then run under extreme and random argument and local counts, with
// random idling on both channels. Each transfer is checked field by field
// against the row's own result if typed, else a frame model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfol_pkg::*;

  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int FRAME_SLOTS = DEF_FRAME_SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_OPS   = 125;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           stat;
    logic              sne;
  } op_result_t;

  typedef struct {
    bit                reconf;
    int unsigned       cfg_args;
    int unsigned       cfg_locals;
    kind_t             k;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] w;
    bit                typed;
    op_result_t        want;
  } op_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [IDX_W-1:0]  slot_index = '0;
  logic [DATA_W-1:0] data_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic              stack_not_empty;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  // frame model state
  logic [DATA_W-1:0] stack_words [STACK_DEPTH];
  logic [DATA_W-1:0] frame_slots [FRAME_SLOTS] = '{default: '0};
  int unsigned       stack_depth = 0;
  int unsigned       n_args = 0;
  int unsigned       n_locals = 0;

  op_result_t        pending_results [$];
  int                mismatches = 0;
  int unsigned       cycle_cnt = 0;
  bit                tx_busy = 1'b0;
  bit                rx_busy = 1'b0;
  bit                hold_req = 1'b0;

  op_row_t dir_tab [25] = '{
    '{1,   0,   0, K_POP,         8'd0,   32'h0,        1, '{32'h0,        STAT_EMPTY, 1'b0}},
    '{0,   0,   0, K_PEEK,        8'd0,   32'h0,        1, '{32'h0,        STAT_EMPTY, 1'b0}},
    '{0,   0,   0, K_LOAD_LOCAL,  8'd0,   32'h0,        1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{0,   0,   0, K_STORE_ARG,   8'd0,   32'h5555aaaa, 1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{0,   0,   0, K_LOAD_ARG,    8'd255, 32'h0,        1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{0,   0,   0, K_NOP,         8'd255, 32'hffffffff, 1, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_PUSH,        8'd0,   32'hffffffff, 1, '{32'h0,        STAT_OK,    1'b1}},
    '{0,   0,   0, K_PEEK,        8'd0,   32'h0,        1, '{32'hffffffff, STAT_OK,    1'b1}},
    '{0,   0,   0, K_POP,         8'd0,   32'h0,        1, '{32'hffffffff, STAT_OK,    1'b0}},
    '{1,   2,   3, K_STORE_ARG,   8'd1,   32'hdeadbeef, 1, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_LOAD_LOCAL,  8'd0,   32'h0,        1, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_STORE_LOCAL, 8'd2,   32'h12345678, 1, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_LOAD_ARG,    8'd4,   32'h0,        0, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_LOAD_LOCAL,  8'd3,   32'h0,        1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{0,   0,   0, K_LOAD_ARG,    8'd5,   32'h0,        1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{0,   0,   0, K_LOAD_ARG,    8'd1,   32'h0,        0, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_STORE_LOCAL, 8'd255, 32'h0,        1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{1, 256, 256, K_LOAD_LOCAL,  8'd0,   32'h0,        1, '{32'h0,        STAT_RANGE, 1'b0}},
    '{0,   0,   0, K_STORE_ARG,   8'd255, 32'ha5a5a5a5, 1, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_LOAD_ARG,    8'd255, 32'h0,        0, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_PUSH,        8'd255, 32'h0,        1, '{32'h0,        STAT_OK,    1'b1}},
    '{0,   0,   0, K_POP,         8'd0,   32'h0,        1, '{32'h0,        STAT_OK,    1'b0}},
    '{1,   0, 256, K_LOAD_LOCAL,  8'd255, 32'h0,        0, '{32'h0,        STAT_OK,    1'b0}},
    '{1, 256,   0, K_LOAD_ARG,    8'd0,   32'h0,        0, '{32'h0,        STAT_OK,    1'b0}},
    '{0,   0,   0, K_STORE_LOCAL, 8'd0,   32'h77777777, 1, '{32'h0,        STAT_RANGE, 1'b0}}
  };

  int unsigned ph_args   [6] = '{0, 256, 0, 256, 1, 5};
  int unsigned ph_locals [6] = '{0, 256, 256, 0, 1, 7};
  int unsigned ph_push   [NUM_PHASES] = '{80, 85, 50, 20, 85, 85, 50, 15, 60, 40};

  stack_frame_operand_and_locals_unit_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .slot_index      (slot_index),
    .data_in         (data_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_out        (data_out),
    .status          (status),
    .stack_not_empty (stack_not_empty),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic op_result_t frame_op(kind_t k, logic [IDX_W-1:0] idx,
                                          logic [DATA_W-1:0] w);
    op_result_t  r;
    int unsigned total;
    int unsigned slot;
    r.value = '0;
    r.stat  = STAT_OK;
    total = n_args + n_locals;
    if (total > FRAME_SLOTS) total = FRAME_SLOTS;
    slot = (k == K_LOAD_LOCAL || k == K_STORE_LOCAL) ? n_args + idx : idx;
    case (k)
      K_PUSH: begin
        if (stack_depth >= STACK_DEPTH) begin
          r.stat = STAT_FULL;
        end else begin
          stack_words[stack_depth] = w;
          stack_depth++;
        end
      end
      K_POP, K_PEEK: begin
        if (stack_depth == 0) begin
          r.stat = STAT_EMPTY;
        end else begin
          r.value = stack_words[stack_depth-1];
          if (k == K_POP) stack_depth--;
        end
      end
      K_LOAD_LOCAL, K_LOAD_ARG: begin
        if (slot >= total) r.stat = STAT_RANGE;
        else r.value = frame_slots[slot];
      end
      K_STORE_LOCAL, K_STORE_ARG: begin
        if (slot >= total) r.stat = STAT_RANGE;
        else frame_slots[slot] = w;
      end
      default: ;
    endcase
    r.sne = (stack_depth != 0);
    return r;
  endfunction

  // called just after a rising edge; returns at the edge of the transfer
  task automatic send_op(input kind_t k, input logic [IDX_W-1:0] idx,
                         input logic [DATA_W-1:0] w, input bit typed,
                         input op_result_t want);
    int         gap;
    op_result_t pred;
    gap = tx_busy ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    slot_index <= idx;
    data_in    <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = frame_op(k, idx, w);
    pending_results.insert(pending_results.size(), typed ? want : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame_counts(input int unsigned a, input int unsigned l);
    apb_write(REG_ARG_COUNT, a);
    apb_write(REG_LOCAL_COUNT, l);
    n_args   = a & 9'h1ff;
    n_locals = l & 9'h1ff;
  endtask

  // receiver: random stall before each transfer, one long hold on request
  initial begin
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = rx_busy ? 0 : $urandom_range(0, 13);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    op_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: data_out %h status %0d", data_out, status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.value) begin
          $error("data_out: expected %h, got %h", want.value, data_out);
          mismatches++;
        end
        if (status !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, status);
          mismatches++;
        end
        if (stack_not_empty !== want.sne) begin
          $error("stack_not_empty: expected %0d, got %0d", want.sne, stack_not_empty);
          mismatches++;
        end
      end
    end
  end

  initial begin
    op_result_t        no_want;
    kind_t             k;
    logic [IDX_W-1:0]  idx;
    int unsigned       total;
    int unsigned       hi;
    int unsigned       r;
    int unsigned       a;
    int unsigned       l;
    no_want = '{value: '0, stat: STAT_OK, sne: 1'b0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].reconf) begin
        drain_results();
        set_frame_counts(dir_tab[i].cfg_args, dir_tab[i].cfg_locals);
      end
      send_op(dir_tab[i].k, dir_tab[i].idx, dir_tab[i].w, dir_tab[i].typed,
              dir_tab[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p < 6) begin
        a = ph_args[p];
        l = ph_locals[p];
      end else begin
        a = $urandom_range(0, 256);
        l = $urandom_range(0, 256);
      end
      set_frame_counts(a, l);
      tx_busy = (p % 4 == 1) || (p == 3);
      rx_busy = (p % 4 == 2);
      if (p == 3) hold_req = 1'b1;
      total = (n_args + n_locals > FRAME_SLOTS) ? FRAME_SLOTS : n_args + n_locals;
      for (int i = 0; i < PHASE_OPS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          k = K_NOP;
        end else if (r < 53) begin
          if ($urandom_range(0, 99) < ph_push[p]) k = K_PUSH;
          else k = $urandom_range(0, 1) ? K_POP : K_PEEK;
        end else begin
          case ($urandom_range(0, 3))
            0: k = K_LOAD_LOCAL;
            1: k = K_STORE_LOCAL;
            2: k = K_LOAD_ARG;
            default: k = K_STORE_ARG;
          endcase
        end
        hi = (k == K_LOAD_LOCAL || k == K_STORE_LOCAL) ? n_locals + 1 : total + 1;
        if (hi > 255) hi = 255;
        idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255)) :
                                            IDX_W'($urandom_range(0, hi));
        send_op(k, idx, $urandom, 1'b0, no_want);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
